### design/cds_pkg.sv
// Shared types, constants and calendar helper functions for the date span unit.
package cds_pkg;

    localparam int unsigned DAY_W  = 7;
    localparam int unsigned MON_W  = 7;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned ORD_W  = 22;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [YEAR_W-1:0] YEAR_LIMIT     = 14'd9999;
    localparam logic [YEAR_W-1:0] RESET_MIN_YEAR = 14'd1950;
    localparam logic [YEAR_W-1:0] RESET_MAX_YEAR = 14'd2024;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'b1;

    // Reciprocals for dividing a day span by 7 and by 365. Both quotients are
    // exact for any span below 2^22, as the rounding error of each constant
    // times the span stays below one unit of the shift.
    localparam int unsigned RCP_W      = 23;
    localparam int unsigned PROD_W     = ORD_W + RCP_W;
    localparam int unsigned WEEK_SHIFT = 25;
    localparam int unsigned YEAR_SHIFT = 31;
    localparam logic [RCP_W-1:0] RCP_WEEK = 23'd4793491;
    localparam logic [RCP_W-1:0] RCP_YEAR = 23'd5883517;

    // Order in which the terms of a day number are accumulated.
    localparam logic [2:0] T_YEARS = 3'd0;
    localparam logic [2:0] T_LEAP4 = 3'd1;
    localparam logic [2:0] T_CENT  = 3'd2;
    localparam logic [2:0] T_QUAD  = 3'd3;
    localparam logic [2:0] T_MONTH = 3'd4;
    localparam logic [2:0] T_DAY   = 3'd5;

    typedef enum logic [1:0] {
        ST_OK,
        ST_START_BAD,
        ST_END_BAD,
        ST_ORDER
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ORD,
        S_DIFF,
        S_INCL,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ORD_W-1:0] a;
        logic [ORD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ORD_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic [DAY_W-1:0]  start_day;
        logic [MON_W-1:0]  start_month;
        logic [YEAR_W-1:0] start_year;
        logic [DAY_W-1:0]  end_day;
        logic [MON_W-1:0]  end_month;
        logic [YEAR_W-1:0] end_year;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [18:0] week_count;
        logic [2:0]  leftover_days;
        logic [21:0] inclusive_days;
        logic [13:0] year_count;
    } t_out_item;

    // Divisibility by 25 through the modular inverse of 25 modulo 2^14.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [27:0] p;
        logic        div25;
        p     = 28'(y) * 28'd7209;
        div25 = (p[13:0] <= 14'd655);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'h0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic date_ok(
        input logic [DAY_W-1:0]  d,
        input logic [MON_W-1:0]  m,
        input logic [YEAR_W-1:0] y,
        input logic              leap,
        input logic [YEAR_W-1:0] min_year,
        input logic [YEAR_W-1:0] max_year
    );
        logic year_ok;
        logic mon_ok;
        year_ok = (y >= min_year) && (y <= max_year) && (y <= YEAR_LIMIT);
        mon_ok  = (m >= 7'd1) && (m <= 7'd12);
        return year_ok && mon_ok && (d >= 7'd1)
            && (d <= {2'b00, month_len(m[3:0], leap)});
    endfunction

    // One term of the day number counted from 1 January of year 0.
    // The century and quad-century counts use reciprocal multiplies.
    function automatic logic [ORD_W-1:0] ord_term(
        input logic [2:0]        idx,
        input logic [DAY_W-1:0]  d,
        input logic [MON_W-1:0]  m,
        input logic [YEAR_W-1:0] y,
        input logic              leap
    );
        logic [14:0]      x;
        logic [27:0]      p;
        logic [ORD_W-1:0] t;
        x = 15'd0;
        p = 28'd0;
        unique case (idx)
            T_YEARS: t = 22'(y) * 22'd365;
            T_LEAP4: begin
                x = {1'b0, y} + 15'd3;
                t = 22'(x[14:2]);
            end
            T_CENT: begin
                x = {1'b0, y} + 15'd99;
                p = 28'(x) * 28'd5243;
                t = 22'(p[27:19]);
            end
            T_QUAD: begin
                x = {1'b0, y} + 15'd399;
                p = 28'(x) * 28'd5243;
                t = 22'(p[27:21]);
            end
            T_MONTH: t = 22'(month_start(m[3:0])) + 22'(leap && (m > 7'd2));
            T_DAY:   t = 22'(d) - 22'd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

### design/calendar_date_span_unit.sv
// Top level of the date span unit: configuration registers, core and output register.
// One item at a time. A valid pair passes the check, 12 day-number steps, the difference, the
// increment, two steps for the reciprocal divisions and the leftover days, and the hand-over;
// an invalid date goes from the check to the hand-over, start after end from the difference.
// The next beat is taken in the cycle after the result is loaded. Synchronous active-low reset
// empties the output register, idles the sequencer, restores 1950..2024.
module calendar_date_span_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cds_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cds_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [cds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cds_pkg::YEAR_W-1:0]       i_cfg_data
);

    logic [cds_pkg::YEAR_W-1:0] r_min_year;
    logic [cds_pkg::YEAR_W-1:0] r_max_year;
    logic                       r_out_valid;
    cds_pkg::t_out_item         r_out;

    logic                       w_busy;
    logic                       w_done;
    logic                       w_out_free;
    cds_pkg::t_out_item         w_result;

    assign w_out_free = !r_out_valid || !i_out_stall;

    cds_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && !w_busy),
        .i_item     (i_in_data),
        .i_min_year (r_min_year),
        .i_max_year (r_max_year),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= cds_pkg::RESET_MIN_YEAR;
            r_max_year <= cds_pkg::RESET_MAX_YEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cds_pkg::CFG_MIN_YEAR: r_min_year <= i_cfg_data;
                cds_pkg::CFG_MAX_YEAR: r_max_year <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### design/cds_alu.sv
// Shared add/subtract unit with borrow flag used for the day-number, difference, increment and leftover-day steps.
module cds_alu (
    input  cds_pkg::t_alu_req i_req,
    output cds_pkg::t_alu_rsp o_rsp
);

    logic [cds_pkg::ORD_W:0] w_sum;

    always_comb begin
        unique case (i_req.op)
            cds_pkg::ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            cds_pkg::ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default:          w_sum = '0;
        endcase
        o_rsp.res    = w_sum[cds_pkg::ORD_W-1:0];
        o_rsp.borrow = (i_req.op == cds_pkg::ALU_SUB) && w_sum[cds_pkg::ORD_W];
    end

endmodule

### design/cds_core.sv
// Sequencer that checks the dates, builds both day numbers and divides the span.
module cds_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  cds_pkg::t_in_item             i_item,
    input  logic [cds_pkg::YEAR_W-1:0]    i_min_year,
    input  logic [cds_pkg::YEAR_W-1:0]    i_max_year,
    input  logic                          i_out_free,
    output logic                          o_busy,
    output logic                          o_done,
    output cds_pkg::t_out_item            o_result
);

    cds_pkg::t_state    r_state, n_state;
    cds_pkg::t_in_item  r_item, n_item;
    cds_pkg::t_status   r_status, n_status;
    logic               r_leap_s, n_leap_s;
    logic               r_leap_e, n_leap_e;
    logic               r_sel, n_sel;
    logic [2:0]         r_term, n_term;
    logic [cds_pkg::ORD_W-1:0] r_acc, n_acc;
    logic [cds_pkg::ORD_W-1:0] r_ord_a, n_ord_a;
    logic [cds_pkg::ORD_W-1:0] r_diff, n_diff;
    logic [cds_pkg::ORD_W-1:0] r_incl, n_incl;
    logic               r_phase, n_phase;
    logic [18:0]        r_week, n_week;
    logic [2:0]         r_left, n_left;
    logic [13:0]        r_years, n_years;

    cds_pkg::t_alu_req  w_req;
    cds_pkg::t_alu_rsp  w_rsp;

    logic [cds_pkg::DAY_W-1:0]  w_d;
    logic [cds_pkg::MON_W-1:0]  w_m;
    logic [cds_pkg::YEAR_W-1:0] w_y;
    logic                       w_leap;
    logic [cds_pkg::PROD_W-1:0] w_wk_prod;
    logic [cds_pkg::PROD_W-1:0] w_yr_prod;
    logic                       w_ok_s;
    logic                       w_ok_e;
    logic                       w_leap_s;
    logic                       w_leap_e;

    cds_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_leap_s <= n_leap_s;
        r_leap_e <= n_leap_e;
        r_sel    <= n_sel;
        r_term   <= n_term;
        r_acc    <= n_acc;
        r_ord_a  <= n_ord_a;
        r_diff   <= n_diff;
        r_incl   <= n_incl;
        r_phase  <= n_phase;
        r_week   <= n_week;
        r_left   <= n_left;
        r_years  <= n_years;
    end

    // Date currently being turned into a day number.
    assign w_d    = r_sel ? r_item.end_day   : r_item.start_day;
    assign w_m    = r_sel ? r_item.end_month : r_item.start_month;
    assign w_y    = r_sel ? r_item.end_year  : r_item.start_year;
    assign w_leap = r_sel ? r_leap_e         : r_leap_s;

    assign w_leap_s = cds_pkg::is_leap(r_item.start_year);
    assign w_leap_e = cds_pkg::is_leap(r_item.end_year);
    assign w_ok_s   = cds_pkg::date_ok(r_item.start_day, r_item.start_month,
                                       r_item.start_year, w_leap_s, i_min_year, i_max_year);
    assign w_ok_e   = cds_pkg::date_ok(r_item.end_day, r_item.end_month,
                                       r_item.end_year, w_leap_e, i_min_year, i_max_year);

    // Quotients of the span by 7 and by 365 through reciprocal multiplies.
    assign w_wk_prod = cds_pkg::PROD_W'(r_diff) * cds_pkg::PROD_W'(cds_pkg::RCP_WEEK);
    assign w_yr_prod = cds_pkg::PROD_W'(r_diff) * cds_pkg::PROD_W'(cds_pkg::RCP_YEAR);

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_status = r_status;
        n_leap_s = r_leap_s;
        n_leap_e = r_leap_e;
        n_sel    = r_sel;
        n_term   = r_term;
        n_acc    = r_acc;
        n_ord_a  = r_ord_a;
        n_diff   = r_diff;
        n_incl   = r_incl;
        n_phase  = r_phase;
        n_week   = r_week;
        n_left   = r_left;
        n_years  = r_years;
        o_done   = 1'b0;

        w_req.op = cds_pkg::ALU_ADD;
        w_req.a  = r_acc;
        w_req.b  = '0;

        unique case (r_state)
            cds_pkg::S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = cds_pkg::S_CHECK;
                end
            end
            cds_pkg::S_CHECK: begin
                n_leap_s = w_leap_s;
                n_leap_e = w_leap_e;
                n_sel    = 1'b0;
                n_term   = cds_pkg::T_YEARS;
                priority if (!w_ok_s) begin
                    n_status = cds_pkg::ST_START_BAD;
                    n_state  = cds_pkg::S_FIN;
                end else if (!w_ok_e) begin
                    n_status = cds_pkg::ST_END_BAD;
                    n_state  = cds_pkg::S_FIN;
                end else begin
                    n_status = cds_pkg::ST_OK;
                    n_state  = cds_pkg::S_ORD;
                end
            end
            cds_pkg::S_ORD: begin
                w_req.op = (r_term == cds_pkg::T_CENT) ? cds_pkg::ALU_SUB : cds_pkg::ALU_ADD;
                w_req.a  = (r_term == cds_pkg::T_YEARS) ? '0 : r_acc;
                w_req.b  = cds_pkg::ord_term(r_term, w_d, w_m, w_y, w_leap);
                n_acc    = w_rsp.res;
                if (r_term == cds_pkg::T_DAY) begin
                    n_term = cds_pkg::T_YEARS;
                    if (!r_sel) begin
                        n_ord_a = w_rsp.res;
                        n_sel   = 1'b1;
                    end else begin
                        n_state = cds_pkg::S_DIFF;
                    end
                end else begin
                    n_term = r_term + 3'd1;
                end
            end
            cds_pkg::S_DIFF: begin
                w_req.op = cds_pkg::ALU_SUB;
                w_req.a  = r_acc;
                w_req.b  = r_ord_a;
                if (w_rsp.borrow) begin
                    n_status = cds_pkg::ST_ORDER;
                    n_state  = cds_pkg::S_FIN;
                end else begin
                    n_diff  = w_rsp.res;
                    n_state = cds_pkg::S_INCL;
                end
            end
            cds_pkg::S_INCL: begin
                w_req.op = cds_pkg::ALU_ADD;
                w_req.a  = r_diff;
                w_req.b  = cds_pkg::ORD_W'(1);
                n_incl   = w_rsp.res;
                n_phase  = 1'b0;
                n_state  = cds_pkg::S_DIV;
            end
            cds_pkg::S_DIV: begin
                if (!r_phase) begin
                    n_week  = w_wk_prod[cds_pkg::WEEK_SHIFT +: 19];
                    n_years = w_yr_prod[cds_pkg::YEAR_SHIFT +: 14];
                    n_phase = 1'b1;
                end else begin
                    // Leftover days are the span less seven times the weeks.
                    w_req.op = cds_pkg::ALU_SUB;
                    w_req.a  = r_diff;
                    w_req.b  = cds_pkg::ORD_W'({r_week, 3'b000})
                             - cds_pkg::ORD_W'(r_week);
                    n_left   = w_rsp.res[2:0];
                    n_state  = cds_pkg::S_FIN;
                end
            end
            cds_pkg::S_FIN: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = cds_pkg::S_IDLE;
                end
            end
            default: n_state = cds_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != cds_pkg::S_IDLE);

    always_comb begin
        o_result.status = r_status;
        if (r_status == cds_pkg::ST_OK) begin
            o_result.week_count     = r_week;
            o_result.leftover_days  = r_left;
            o_result.inclusive_days = r_incl;
            o_result.year_count     = r_years;
        end else begin
            o_result.week_count     = '0;
            o_result.leftover_days  = '0;
            o_result.inclusive_days = '0;
            o_result.year_count     = '0;
        end
    end

endmodule

### design/cds_checker.sv
// Port-level checker for the date span unit and its bind to the top level.
module cds_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input cds_pkg::t_in_item                i_in_data,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input cds_pkg::t_out_item               o_out_data,
    input logic                             i_cfg_we,
    input logic [cds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [cds_pkg::YEAR_W-1:0]       i_cfg_data
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // An accepted item keeps the input side busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // A rejected pair carries no span.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != cds_pkg::ST_OK) |->
            (o_out_data.week_count == '0) && (o_out_data.leftover_days == '0)
            && (o_out_data.inclusive_days == '0) && (o_out_data.year_count == '0))
        else $error("non-zero span with error status");

    // Weeks and leftover days must rebuild the inclusive count.
    a_span_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == cds_pkg::ST_OK) |->
            (o_out_data.leftover_days <= 3'd6)
            && ((22'(o_out_data.week_count) * 22'd7 + 22'(o_out_data.leftover_days)
                 + 22'd1) == o_out_data.inclusive_days))
        else $error("weeks and leftover days disagree with inclusive count");

endmodule

bind calendar_date_span_unit cds_checker u_cds_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the calendar date span unit.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned RESULT_WAIT = 1000;
    localparam int unsigned SETTLE      = 70;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          out_stall = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [cds_pkg::CFG_IDX_W-1:0] cfg_index = cds_pkg::CFG_MIN_YEAR;
    logic [cds_pkg::YEAR_W-1:0]    cfg_data  = '0;
    cds_pkg::t_in_item             in_data   = '0;
    logic                          in_stall;
    logic                          out_valid;
    cds_pkg::t_out_item            out_data;

    // Year window as the block should currently hold it.
    bit [cds_pkg::YEAR_W-1:0] win_min = cds_pkg::RESET_MIN_YEAR;
    bit [cds_pkg::YEAR_W-1:0] win_max = cds_pkg::RESET_MAX_YEAR;

    cds_pkg::t_out_item span_q[$];
    bit          idling_on  = 1'b1;
    int unsigned stall_left = 0;
    int unsigned err_count  = 0;
    int unsigned beat_count = 0;

    calendar_date_span_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_valid(int unsigned d, int unsigned m, int unsigned y);
        if (y < win_min || y > win_max || y > cds_pkg::YEAR_LIMIT)
            return 1'b0;
        if (m < 1 || m > 12)
            return 1'b0;
        return (d >= 1) && (d <= month_days(m, y));
    endfunction

    // Days since 1 January of year 0; year 0 itself is a leap year.
    function automatic int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
        int unsigned n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d - 1;
        for (int unsigned k = 1; k < m; k++)
            n += month_days(k, 1);
        if (m > 2 && leap_year(y))
            n++;
        return n;
    endfunction

    function automatic cds_pkg::t_out_item span_of(cds_pkg::t_in_item it);
        cds_pkg::t_out_item r;
        int unsigned a;
        int unsigned b;
        int unsigned diff;
        r = '0;
        r.status = cds_pkg::ST_OK;
        if (!date_valid(it.start_day, it.start_month, it.start_year)) begin
            r.status = cds_pkg::ST_START_BAD;
        end else if (!date_valid(it.end_day, it.end_month, it.end_year)) begin
            r.status = cds_pkg::ST_END_BAD;
        end else begin
            a = day_number(it.start_day, it.start_month, it.start_year);
            b = day_number(it.end_day, it.end_month, it.end_year);
            if (a > b) begin
                r.status = cds_pkg::ST_ORDER;
            end else begin
                diff             = b - a;
                r.week_count     = 19'(diff / 7);
                r.leftover_days  = 3'(diff % 7);
                r.inclusive_days = 22'(diff + 1);
                r.year_count     = 14'(diff / 365);
            end
        end
        return r;
    endfunction

    function automatic cds_pkg::t_in_item mk_item(int unsigned sd, int unsigned sm,
                                                  int unsigned sy, int unsigned ed,
                                                  int unsigned em, int unsigned ey);
        cds_pkg::t_in_item it;
        it.start_day   = cds_pkg::DAY_W'(sd);
        it.start_month = cds_pkg::MON_W'(sm);
        it.start_year  = cds_pkg::YEAR_W'(sy);
        it.end_day     = cds_pkg::DAY_W'(ed);
        it.end_month   = cds_pkg::MON_W'(em);
        it.end_year    = cds_pkg::YEAR_W'(ey);
        return it;
    endfunction

    // A valid date inside the window, or any real date when the window is empty.
    function automatic void pick_date(output int unsigned d, output int unsigned m,
                                      output int unsigned y);
        int unsigned hi;
        hi = (win_max > cds_pkg::YEAR_LIMIT) ? cds_pkg::YEAR_LIMIT : win_max;
        if (win_min <= hi)
            y = $urandom_range(hi, win_min);
        else
            y = $urandom_range(cds_pkg::YEAR_LIMIT, 0);
        m = $urandom_range(12, 1);
        d = $urandom_range(month_days(m, y), 1);
    endfunction

    function automatic cds_pkg::t_in_item random_pair();
        cds_pkg::t_in_item it;
        int unsigned sd, sm, sy, ed, em, ey;
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 12) begin
            it.start_day   = cds_pkg::DAY_W'($urandom);
            it.start_month = cds_pkg::MON_W'($urandom);
            it.start_year  = cds_pkg::YEAR_W'($urandom);
            it.end_day     = cds_pkg::DAY_W'($urandom);
            it.end_month   = cds_pkg::MON_W'($urandom);
            it.end_year    = cds_pkg::YEAR_W'($urandom);
            return it;
        end
        pick_date(sd, sm, sy);
        pick_date(ed, em, ey);
        if (pick >= 24 && pick < 30) begin
            ed = sd;
            em = sm;
            ey = sy;
        end
        // Most pairs are put in order; the top tenth keeps whatever order came out.
        if (pick < 90 && day_number(sd, sm, sy) > day_number(ed, em, ey))
            it = mk_item(ed, em, ey, sd, sm, sy);
        else
            it = mk_item(sd, sm, sy, ed, em, ey);
        if (pick >= 12 && pick < 24) begin
            case ($urandom_range(5, 0))
                0:       it.start_day   = cds_pkg::DAY_W'($urandom);
                1:       it.start_month = cds_pkg::MON_W'($urandom);
                2:       it.start_year  = cds_pkg::YEAR_W'($urandom);
                3:       it.end_day     = cds_pkg::DAY_W'($urandom);
                4:       it.end_month   = cds_pkg::MON_W'($urandom);
                default: it.end_year    = cds_pkg::YEAR_W'($urandom);
            endcase
        end
        return it;
    endfunction

    task automatic report(string msg);
        $display("%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_item(cds_pkg::t_in_item it);
        if (idling_on && $urandom_range(3, 0) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        span_q.push_back(span_of(it));
    endtask

    task automatic send_random(int unsigned count);
        repeat (count) send_item(random_pair());
    endtask

    task automatic wait_for_results();
        int unsigned n;
        n = 0;
        in_valid <= 1'b0;
        while (span_q.size() != 0 && n < RESULT_WAIT) begin
            @(posedge clk);
            n++;
        end
        if (span_q.size() != 0) begin
            report($sformatf("%0d expected results never arrived", span_q.size()));
            span_q.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_window(int unsigned lo, int unsigned hi);
        cfg_we    <= 1'b1;
        cfg_index <= cds_pkg::CFG_MIN_YEAR;
        cfg_data  <= cds_pkg::YEAR_W'(lo);
        @(posedge clk);
        cfg_index <= cds_pkg::CFG_MAX_YEAR;
        cfg_data  <= cds_pkg::YEAR_W'(hi);
        @(posedge clk);
        cfg_we  <= 1'b0;
        win_min = cds_pkg::YEAR_W'(lo);
        win_max = cds_pkg::YEAR_W'(hi);
        @(posedge clk);
    endtask

    // Window left at its reset value of 1950..2024.
    task automatic test_default_window();
        send_item(mk_item(1, 1, 1950, 31, 12, 2024));
        send_item(mk_item(29, 2, 2000, 29, 2, 2000));
        send_item(mk_item(1, 1, 2024, 31, 12, 2024));
        send_item(mk_item(0, 1, 2000, 1, 1, 2001));
        send_item(mk_item(1, 1, 2000, 32, 1, 2001));
        send_item(mk_item(0, 0, 0, 0, 0, 0));
        send_item(mk_item(1, 3, 2020, 28, 2, 2020));
        send_item(mk_item(29, 2, 2023, 1, 3, 2023));
        send_item(mk_item(1, 13, 2000, 1, 1, 2001));
        send_item(mk_item(127, 127, 16383, 127, 127, 16383));
        send_item(mk_item(1, 1, 1949, 1, 1, 2000));
        send_item(mk_item(1, 1, 2000, 1, 1, 2025));
        send_item(mk_item(31, 4, 2001, 30, 4, 2001));
        send_item(mk_item(30, 4, 2001, 31, 12, 2001));
        send_random(40);
        wait_for_results();
    endtask

    // Widest register settings, so the 9999 ceiling is the only year bound.
    task automatic test_full_window();
        set_window(0, 16383);
        send_item(mk_item(29, 2, 0, 1, 3, 0));
        send_item(mk_item(1, 1, 0, 31, 12, 9999));
        send_item(mk_item(29, 2, 1900, 1, 3, 1900));
        send_item(mk_item(29, 2, 2000, 1, 3, 2000));
        send_item(mk_item(1, 1, 10000, 1, 1, 10001));
        send_item(mk_item(1, 1, 9999, 1, 1, 16383));
        send_item(mk_item(31, 12, 9999, 1, 1, 0));
        send_random(400);
        wait_for_results();
    endtask

    // Minimum above maximum: every start date fails.
    task automatic test_empty_window();
        set_window(9999, 0);
        send_item(mk_item(1, 1, 2000, 2, 1, 2000));
        send_random(40);
        wait_for_results();
    endtask

    task automatic test_single_year();
        set_window(2000, 2000);
        send_random(150);
        wait_for_results();
    endtask

    task automatic test_random_windows();
        int unsigned lo;
        int unsigned hi;
        repeat (4) begin
            lo = $urandom_range(cds_pkg::YEAR_LIMIT, 0);
            hi = lo + $urandom_range(300, 0);
            if ($urandom_range(3, 0) == 0)
                hi = 16383;
            set_window(lo, hi);
            send_random(175);
            wait_for_results();
        end
    endtask

    // Last stretch runs with both sides always ready.
    task automatic test_back_to_back();
        idling_on = 1'b0;
        set_window(cds_pkg::RESET_MIN_YEAR, cds_pkg::RESET_MAX_YEAR);
        send_random(360);
        wait_for_results();
    endtask

    always @(posedge clk) begin : drive_out_stall
        if (stall_left != 0)
            stall_left--;
        else if (idling_on && $urandom_range(5, 0) == 0)
            stall_left = $urandom_range(18, 1);
        out_stall <= (stall_left != 0);
    end

    always @(posedge clk) begin : check_results
        cds_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            beat_count++;
            if (span_q.size() == 0) begin
                report($sformatf("result beat %0d arrived with nothing expected", beat_count));
            end else begin
                want = span_q.pop_front();
                if (out_data.status !== want.status)
                    report($sformatf("beat %0d status %0d, expected %0d",
                                     beat_count, out_data.status, want.status));
                if (out_data.week_count !== want.week_count)
                    report($sformatf("beat %0d week_count %0d, expected %0d",
                                     beat_count, out_data.week_count, want.week_count));
                if (out_data.leftover_days !== want.leftover_days)
                    report($sformatf("beat %0d leftover_days %0d, expected %0d",
                                     beat_count, out_data.leftover_days, want.leftover_days));
                if (out_data.inclusive_days !== want.inclusive_days)
                    report($sformatf("beat %0d inclusive_days %0d, expected %0d",
                                     beat_count, out_data.inclusive_days,
                                     want.inclusive_days));
                if (out_data.year_count !== want.year_count)
                    report($sformatf("beat %0d year_count %0d, expected %0d",
                                     beat_count, out_data.year_count, want.year_count));
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_window();
        test_full_window();
        test_empty_window();
        test_single_year();
        test_random_windows();
        test_back_to_back();
        if (err_count == 0) begin
            $display("** calendar_date_span_unit: PASSED **");
        end else begin
            $display("** calendar_date_span_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("** calendar_date_span_unit: FAILED **");
        $finish;
    end

endmodule

### filelist.f
design/cds_pkg.sv
design/cds_alu.sv
design/cds_core.sv
design/calendar_date_span_unit.sv
design/cds_checker.sv
tb/tb_top.sv
